// File: src/cpac_pkg.sv
// Package: types, constants and helpers for the cascaded PID attitude controller.
`timescale 1ns / 1ps
`default_nettype none
package cpac_pkg;
    localparam int DATA_W = 32;
    localparam int GAIN_W = 48;
    localparam int DT_WIDTH_DEF = 20;
    localparam int DT_IN_W = 20;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_HOME_LAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_LON = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POS_GAINS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_GAINS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROLL_GAINS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_GAINS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ALT_GAINS = 3'd6;

    localparam logic [2:0] LOOP_LAT = 3'd0;
    localparam logic [2:0] LOOP_LON = 3'd1;
    localparam logic [2:0] LOOP_PITCH = 3'd2;
    localparam logic [2:0] LOOP_ROLL = 3'd3;
    localparam logic [2:0] LOOP_YAW = 3'd4;
    localparam logic [2:0] LOOP_ALT = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ERR,
        ST_INC,
        ST_INT,
        ST_DIV,
        ST_KP,
        ST_KI,
        ST_KD,
        ST_DONE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction
endpackage
`default_nettype wire

// File: src/cpac_if.sv
// Valid/ready channel interface carrying one payload.
`timescale 1ns / 1ps
`default_nettype none
interface cpac_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: src/cpac_div.sv
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
`timescale 1ns / 1ps
`default_nettype none
module cpac_div (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire cpac_pkg::div_req_t req,
    input  wire logic signed [32:0] dividend,
    output cpac_pkg::div_stat_t     stat,
    output logic signed [32:0]      quotient
);
    import cpac_pkg::*;
    logic [32:0] rem_reg, rem_next;
    logic [32:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] trial;
    logic [32:0] shifted;

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted = {rem_reg[31:0], quo_reg[32]};
        trial = {1'b0, shifted} - {2'b00, dvs_reg};
        if (req.start)
        begin
            quo_next = dividend[32] ? 33'(-dividend) : dividend;
            neg_next = dividend[32];
            dvs_next = req.divisor;
            rem_next = '0;
            cnt_next = 6'd33;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[33])
            begin
                rem_next = trial[32:0];
                quo_next = {quo_reg[31:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[31:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient = neg_reg ? 33'(-quo_reg) : quo_reg;
endmodule
`default_nettype wire

// File: src/cascaded_pid_attitude_controller_unit.sv
// Top level: sequencer running up to six PID evaluations on one shared multiplier and divider.
// Each evaluated loop waits on the 33-step serial divider for its derivative.
// Three to six loops run per tick. One tick is in flight at a time; in.ready is low
// from acceptance until the result leaves.
// Reset: asynchronous, active low; clears errors, integrals, targets, gains and home.
`timescale 1ns / 1ps
`default_nettype none
module cascaded_pid_attitude_controller_unit #(
    parameter int DT_WIDTH = cpac_pkg::DT_WIDTH_DEF
) (
    input wire clk,
    input wire rst_n,
    cpac_if.sink   in_ch,
    cpac_if.sink   cfg_ch,
    cpac_if.source out_ch
);
    import cpac_pkg::*;

    state_t state_reg, state_next;
    logic signed [31:0] home_lat_reg, home_lon_reg;
    logic [GAIN_W-1:0] gains_reg [5];
    logic signed [31:0] prev_reg [6];
    logic signed [31:0] integ_reg [6];
    logic signed [31:0] lat_t_reg, lon_t_reg, alt_t_reg;
    logic loaded_reg;

    logic signed [31:0] m_roll, m_pitch, m_yaw, m_alt, m_lat, m_lon;
    logic signed [31:0] c_roll, c_pitch, c_yaw, c_thrust;
    logic [DT_WIDTH-1:0] fdt_reg, sdt_reg;
    logic [10*32-1:0] item_reg;

    logic [2:0] loop_reg, loop_next;
    logic signed [31:0] err_reg, tgt_roll_reg, tgt_pitch_reg;
    logic signed [63:0] acc_reg, inc_reg;
    logic signed [32:0] der_reg;
    logic signed [31:0] drv_reg [4];
    logic out_valid_reg;

    logic signed [31:0] p_cur, i_cur, tgt;
    logic [GAIN_W-1:0] g_cur;
    logic [DT_WIDTH-1:0] dt_cur;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] prod;
    logic signed [32:0] sum2;
    logic signed [32:0] half;
    logic signed [64:0] raw;
    logic pos_hold;
    div_req_t dreq;
    div_stat_t dstat;
    logic signed [32:0] dquo;

    assign m_roll = item_reg[31:0];
    assign m_pitch = item_reg[63:32];
    assign m_yaw = item_reg[95:64];
    assign m_alt = item_reg[127:96];
    assign m_lat = item_reg[159:128];
    assign m_lon = item_reg[191:160];
    assign c_roll = item_reg[223:192];
    assign c_pitch = item_reg[255:224];
    assign c_yaw = item_reg[287:256];
    assign c_thrust = item_reg[319:288];
    assign pos_hold = (c_roll == 32'sd0) && (c_pitch == 32'sd0);

    // gain slot: position loops share slot 0
    always_comb
    begin
        case (loop_reg)
            LOOP_LAT, LOOP_LON: g_cur = gains_reg[0];
            LOOP_PITCH: g_cur = gains_reg[1];
            LOOP_ROLL: g_cur = gains_reg[2];
            LOOP_YAW: g_cur = gains_reg[3];
            default: g_cur = gains_reg[4];
        endcase
        case (loop_reg)
            LOOP_PITCH, LOOP_ROLL, LOOP_YAW: dt_cur = fdt_reg;
            default: dt_cur = sdt_reg;
        endcase
        case (loop_reg)
            LOOP_LAT: raw = 65'(m_lat) - 65'(lat_t_reg);
            LOOP_LON: raw = 65'(m_lon) - 65'(lon_t_reg);
            LOOP_PITCH: raw = 65'(m_pitch) - 65'(tgt_pitch_reg);
            LOOP_ROLL: raw = 65'(m_roll) - 65'(tgt_roll_reg);
            LOOP_YAW: raw = 65'(m_yaw) - 65'(c_yaw);
            default: raw = 65'(m_alt) - 65'(alt_t_reg);
        endcase
        tgt = '0;
        p_cur = prev_reg[loop_reg];
        i_cur = integ_reg[loop_reg];
    end

    assign sum2 = 33'(err_reg) + 33'(p_cur);
    assign half = (sum2 + (sum2[32] ? 33'sd1 : 33'sd0)) >>> 1;

    // shared multiplier operands per step
    always_comb
    begin
        case (state_reg)
            ST_INC:
            begin
                mul_a = half;
                mul_b = 33'($signed({1'b0, dt_cur}));
            end
            ST_KP:
            begin
                mul_a = 33'($signed(g_cur[15:0]));
                mul_b = 33'(err_reg);
            end
            ST_KI:
            begin
                mul_a = 33'($signed(g_cur[31:16]));
                mul_b = 33'(i_cur);
            end
            ST_KD:
            begin
                mul_a = 33'($signed(g_cur[47:32]));
                mul_b = der_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign prod = mul_a * mul_b;

    assign dreq.start = (state_reg == ST_ERR);
    assign dreq.divisor = 32'(dt_cur);

    cpac_div u_div (
        .clk(clk), .rst_n(rst_n), .req(dreq),
        .dividend(33'(sat32(64'(raw))) - 33'(p_cur)),
        .stat(dstat), .quotient(dquo)
    );

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.payload = {drv_reg[3], drv_reg[2], drv_reg[1], drv_reg[0]};

    // next loop in the order lat, lon, pitch, roll, yaw, alt
    always_comb
    begin
        loop_next = loop_reg + 3'd1;
        if (loop_reg == LOOP_YAW && c_thrust != 32'sd0)
            loop_next = LOOP_YAW;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_ch.valid) state_next = ST_SETUP;
            ST_SETUP: state_next = ST_ERR;
            ST_ERR: state_next = ST_INC;
            ST_INC: state_next = ST_INT;
            ST_INT: state_next = ST_DIV;
            ST_DIV: if (dstat.done) state_next = ST_KP;
            ST_KP: state_next = ST_KI;
            ST_KI: state_next = ST_KD;
            ST_KD: state_next = ST_DONE;
            ST_DONE:
                if (loop_reg == LOOP_ALT || (loop_reg == LOOP_YAW && c_thrust != 32'sd0))
                    state_next = ST_OUT;
                else
                    state_next = ST_ERR;
            ST_OUT: if (out_ch.ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            home_lat_reg <= '0;
            home_lon_reg <= '0;
            for (int i = 0; i < 5; i++) gains_reg[i] <= '0;
            for (int i = 0; i < 6; i++)
            begin
                prev_reg[i] <= '0;
                integ_reg[i] <= '0;
            end
            lat_t_reg <= '0;
            lon_t_reg <= '0;
            alt_t_reg <= '0;
            loaded_reg <= 1'b0;
            loop_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_ch.valid)
            begin
                case (cfg_ch.payload.index)
                    REG_HOME_LAT: home_lat_reg <= cfg_ch.payload.data[31:0];
                    REG_HOME_LON: home_lon_reg <= cfg_ch.payload.data[31:0];
                    REG_POS_GAINS: gains_reg[0] <= cfg_ch.payload.data;
                    REG_PITCH_GAINS: gains_reg[1] <= cfg_ch.payload.data;
                    REG_ROLL_GAINS: gains_reg[2] <= cfg_ch.payload.data;
                    REG_YAW_GAINS: gains_reg[3] <= cfg_ch.payload.data;
                    REG_ALT_GAINS: gains_reg[4] <= cfg_ch.payload.data;
                    default: ;
                endcase
            end
            case (state_reg)
                ST_SETUP:
                begin
                    if (!loaded_reg)
                    begin
                        lat_t_reg <= home_lat_reg;
                        lon_t_reg <= home_lon_reg;
                        loaded_reg <= 1'b1;
                    end
                    if (pos_hold)
                        loop_reg <= LOOP_LAT;
                    else
                    begin
                        loop_reg <= LOOP_PITCH;
                        lat_t_reg <= m_lat;
                        lon_t_reg <= m_lon;
                    end
                    if (c_thrust != 32'sd0)
                        alt_t_reg <= m_alt;
                end
                ST_INT:
                begin
                    if (inc_reg > 64'sh10000000000)
                        integ_reg[loop_reg] <= sat32(64'(i_cur) + 64'sh10000000000);
                    else if (inc_reg < -64'sh10000000000)
                        integ_reg[loop_reg] <= sat32(64'(i_cur) - 64'sh10000000000);
                    else
                        integ_reg[loop_reg] <= sat32(64'(i_cur) + inc_reg);
                    prev_reg[loop_reg] <= err_reg;
                end
                ST_DONE: loop_reg <= loop_next;
                default: ;
            endcase
            if (state_reg == ST_DONE && state_next == ST_OUT)
                out_valid_reg <= 1'b1;
            else if (state_reg == ST_OUT && out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_ch.valid)
        begin
            item_reg <= {in_ch.payload.command_thrust, in_ch.payload.command_yaw,
                         in_ch.payload.command_pitch, in_ch.payload.command_roll,
                         in_ch.payload.measured_longitude, in_ch.payload.measured_latitude,
                         in_ch.payload.measured_altitude, in_ch.payload.measured_yaw,
                         in_ch.payload.measured_pitch, in_ch.payload.measured_roll};
            fdt_reg <= DT_WIDTH'(in_ch.payload.fast_dt);
            sdt_reg <= DT_WIDTH'(in_ch.payload.slow_dt);
        end
        case (state_reg)
            ST_SETUP:
            begin
                tgt_roll_reg <= c_roll;
                tgt_pitch_reg <= c_pitch;
                drv_reg[3] <= c_thrust;
            end
            ST_ERR: err_reg <= sat32(64'(raw));
            ST_INC: inc_reg <= 64'(prod);
            ST_DIV: der_reg <= (dt_cur == '0) ? 33'sd0 : dquo;
            ST_KP: acc_reg <= 64'(prod);
            ST_KI: acc_reg <= acc_reg + 64'(prod);
            ST_KD:
            begin
                case (loop_reg)
                    LOOP_LAT: tgt_roll_reg <= sat32(acc_reg + 64'(prod));
                    LOOP_LON: tgt_pitch_reg <= sat32(acc_reg + 64'(prod));
                    LOOP_PITCH: drv_reg[1] <= sat32(acc_reg + 64'(prod));
                    LOOP_ROLL: drv_reg[0] <= sat32(acc_reg + 64'(prod));
                    LOOP_YAW: drv_reg[2] <= sat32(acc_reg + 64'(prod));
                    default: drv_reg[3] <= sat32(acc_reg + 64'(prod));
                endcase
            end
            default: ;
        endcase
    end

    logic unused_ok;
    assign unused_ok = ^{tgt, dstat.busy};
endmodule
`default_nettype wire

// File: sim/tb_cascaded_pid_attitude_controller_unit.sv
// Testbench for the cascaded PID attitude controller: directed table then random ticks, scoreboarded.
`timescale 1ns / 1ps
module tb_cascaded_pid_attitude_controller_unit;
    import cpac_pkg::*;

    typedef struct packed {
        logic signed [31:0] measured_roll;
        logic signed [31:0] measured_pitch;
        logic signed [31:0] measured_yaw;
        logic signed [31:0] measured_altitude;
        logic signed [31:0] measured_latitude;
        logic signed [31:0] measured_longitude;
        logic signed [31:0] command_roll;
        logic signed [31:0] command_pitch;
        logic signed [31:0] command_yaw;
        logic signed [31:0] command_thrust;
        logic [DT_IN_W-1:0] fast_dt;
        logic [DT_IN_W-1:0] slow_dt;
    } tick_t;

    // roll in the low bits, thrust in the high bits
    typedef struct packed {
        logic signed [31:0] thrust_drive;
        logic signed [31:0] yaw_drive;
        logic signed [31:0] pitch_drive;
        logic signed [31:0] roll_drive;
    } drive_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_t;

    typedef struct {
        tick_t  tick;
        bit     typed;
        drive_t drv;
    } row_t;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int SETTLE = 300;
    localparam longint CYCLE_LIMIT = 4000000;
    localparam int N_PHASES = 8;
    localparam int PHASE_TICKS = 106;

    logic clk;
    logic rst_n;

    cpac_if #(.payload_t(tick_t))  in_ch ();
    cpac_if #(.payload_t(cfg_t))   cfg_ch ();
    cpac_if #(.payload_t(drive_t)) out_ch ();

    cascaded_pid_attitude_controller_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .cfg_ch (cfg_ch),
        .out_ch (out_ch)
    );

    // controller shadow state
    logic [31:0] home_lat, home_lon;
    logic [47:0] gains [0:6];
    longint prev_err [0:5];
    longint int_sum [0:5];
    longint lat_tgt, lon_tgt, alt_tgt;
    bit     tgt_loaded;

    drive_t pending_drives [$];
    int     fail_count;
    bit     quiet;
    longint cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clip32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint loop_eval(input int idx, input logic [47:0] g,
                                         input longint raw, input longint dt);
        longint kp, ki, kd, e, p, inc, der;
        kp = longint'($signed(g[15:0]));
        ki = longint'($signed(g[31:16]));
        kd = longint'($signed(g[47:32]));
        e = clip32(raw);
        p = prev_err[idx];
        inc = ((e + p) / 2) * dt;
        if (inc > (64'sd1 <<< 40)) inc = 64'sd1 <<< 40;
        if (inc < -(64'sd1 <<< 40)) inc = -(64'sd1 <<< 40);
        int_sum[idx] = clip32(int_sum[idx] + inc);
        der = (dt != 0) ? (e - p) / dt : 0;
        prev_err[idx] = e;
        return clip32(kp * e + ki * int_sum[idx] + kd * der);
    endfunction

    function automatic drive_t predict_drives(input tick_t t);
        drive_t d;
        longint t_roll, t_pitch, fdt, sdt;
        fdt = longint'(t.fast_dt);
        sdt = longint'(t.slow_dt);
        if (!tgt_loaded)
        begin
            lat_tgt = longint'($signed(home_lat));
            lon_tgt = longint'($signed(home_lon));
            tgt_loaded = 1'b1;
        end
        if (t.command_roll == 0 && t.command_pitch == 0)
        begin
            t_roll = loop_eval(LOOP_LAT, gains[REG_POS_GAINS],
                               longint'(t.measured_latitude) - lat_tgt, sdt);
            t_pitch = loop_eval(LOOP_LON, gains[REG_POS_GAINS],
                                longint'(t.measured_longitude) - lon_tgt, sdt);
        end
        else
        begin
            t_roll = t.command_roll;
            t_pitch = t.command_pitch;
            lat_tgt = t.measured_latitude;
            lon_tgt = t.measured_longitude;
        end
        d.pitch_drive = 32'(loop_eval(LOOP_PITCH, gains[REG_PITCH_GAINS],
                                      longint'(t.measured_pitch) - t_pitch, fdt));
        d.roll_drive = 32'(loop_eval(LOOP_ROLL, gains[REG_ROLL_GAINS],
                                     longint'(t.measured_roll) - t_roll, fdt));
        d.yaw_drive = 32'(loop_eval(LOOP_YAW, gains[REG_YAW_GAINS],
                                    longint'(t.measured_yaw) - longint'(t.command_yaw), fdt));
        if (t.command_thrust == 0)
            d.thrust_drive = 32'(loop_eval(LOOP_ALT, gains[REG_ALT_GAINS],
                                           longint'(t.measured_altitude) - alt_tgt, sdt));
        else
        begin
            d.thrust_drive = t.command_thrust;
            alt_tgt = t.measured_altitude;
        end
        return d;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(2);
        if (r < 95) return $urandom_range(20, 3);
        return $urandom_range(400, 50);
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d", field, $signed(got), $signed(want));
        fail_count++;
    endtask

    // result side: random back-pressure and scoreboard
    int stall;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_drives.size() == 0)
                begin
                    $display("unexpected result beat");
                    fail_count++;
                end
                else
                begin
                    drive_t w, g;
                    w = pending_drives.pop_front();
                    g = out_ch.payload;
                    if (g.roll_drive !== w.roll_drive)
                        report_mismatch("roll_drive", g.roll_drive, w.roll_drive);
                    if (g.pitch_drive !== w.pitch_drive)
                        report_mismatch("pitch_drive", g.pitch_drive, w.pitch_drive);
                    if (g.yaw_drive !== w.yaw_drive)
                        report_mismatch("yaw_drive", g.yaw_drive, w.yaw_drive);
                    if (g.thrust_drive !== w.thrust_drive)
                        report_mismatch("thrust_drive", g.thrust_drive, w.thrust_drive);
                end
                stall = pick_gap();
            end
            else if (stall == 0 && !quiet && $urandom_range(7) == 0)
                stall = pick_gap();
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                stall--;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("cascaded_pid_attitude_controller_unit verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.payload <= '{index: idx, data: val};
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_HOME_LAT: home_lat = val[31:0];
            REG_HOME_LON: home_lon = val[31:0];
            REG_POS_GAINS, REG_PITCH_GAINS, REG_ROLL_GAINS,
            REG_YAW_GAINS, REG_ALT_GAINS: gains[idx] = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // drop valid so a waiting beat is not taken twice
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_drives.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_tick(input tick_t t, input bit typed, input drive_t typed_drv);
        drive_t d;
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.payload <= t;
        do @(posedge clk); while (!in_ch.ready);
        d = predict_drives(t);
        pending_drives.push_back(typed ? typed_drv : d);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] rand_val();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 32'h7fffffff;
        if (r == 1) return 32'h80000000;
        if (r < 5) return $urandom();
        return 32'($signed($urandom_range(4000)) - 2000);
    endfunction

    function automatic logic [19:0] rand_dt();
        int r;
        r = $urandom_range(19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r < 4) return 20'($urandom());
        return 20'($urandom_range(64, 1));
    endfunction

    function automatic tick_t rand_tick();
        tick_t t;
        t.measured_roll = rand_val();
        t.measured_pitch = rand_val();
        t.measured_yaw = rand_val();
        t.measured_altitude = rand_val();
        t.measured_latitude = rand_val();
        t.measured_longitude = rand_val();
        // position hold about half the time, altitude hold likewise
        if ($urandom_range(1))
        begin
            t.command_roll = 0;
            t.command_pitch = 0;
        end
        else
        begin
            t.command_roll = $urandom_range(2) ? rand_val() : 0;
            t.command_pitch = (t.command_roll == 0 || $urandom_range(2)) ? rand_val() : 0;
        end
        t.command_yaw = rand_val();
        t.command_thrust = $urandom_range(1) ? 32'd0 : rand_val();
        t.fast_dt = rand_dt();
        t.slow_dt = rand_dt();
        return t;
    endfunction

    function automatic logic [47:0] rand_gains(input int kind);
        logic [47:0] g;
        for (int k = 0; k < 3; k++)
            g[k*16 +: 16] = (kind == 0) ? 16'($urandom())
                                        : 16'($signed($urandom_range(64)) - 32);
        return g;
    endfunction

    function automatic row_t mk_row(input logic [31:0] mr, mp, my, ma, mla, mlo,
                                    input logic [31:0] cr, cp, cy, ct,
                                    input logic [19:0] fd, sd, input bit typed);
        row_t r;
        r.tick = '{mr, mp, my, ma, mla, mlo, cr, cp, cy, ct, fd, sd};
        r.typed = typed;
        // with zero gains every loop gives zero; thrust passes through when commanded
        r.drv = '{roll_drive: 32'd0, pitch_drive: 32'd0, yaw_drive: 32'd0, thrust_drive: ct};
        return r;
    endfunction

    row_t rows [$];

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.payload = '0;
        fail_count = 0;
        cycles = 0;
        quiet = 1'b0;
        home_lat = '0;
        home_lon = '0;
        for (int i = 0; i < 7; i++) gains[i] = '0;
        for (int i = 0; i < 6; i++)
        begin
            prev_err[i] = 0;
            int_sum[i] = 0;
        end
        lat_tgt = 0;
        lon_tgt = 0;
        alt_tgt = 0;
        tgt_loaded = 1'b0;

        // rows at zero gains: results obvious
        rows.push_back(mk_row(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                              32'h7fffffff, 32'h80000000, 0, 0, 32'h80000000, 0,
                              20'hfffff, 20'hfffff, 1));
        rows.push_back(mk_row(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                              32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                              32'h7fffffff, 32'h80000000, 0, 0, 1));
        rows.push_back(mk_row(1, 2, 3, 4, 5, 6, 0, 7, 8, 32'h7fffffff, 1, 1, 1));
        rows.push_back(mk_row(-1, -2, -3, -4, -5, -6, 9, 0, 0, -1, 3, 0, 1));
        rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 5, 1));
        // with gains set: targets, saturation, zero time steps, idle loops
        rows.push_back(mk_row(100, -100, 50, 1000, 2000, -2000, 0, 0, 10, 0, 4, 8, 0));
        rows.push_back(mk_row(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                              32'h7fffffff, 32'h80000000, 0, 0, 32'h80000000, 0,
                              20'hfffff, 20'hfffff, 0));
        rows.push_back(mk_row(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000,
                              32'h80000000, 32'h7fffffff, 0, 0, 32'h7fffffff, 0,
                              20'hfffff, 1, 0));
        rows.push_back(mk_row(5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 0, 0, 0));
        rows.push_back(mk_row(5, 6, 7, 8, 9, 10, 0, 0, 13, 0, 0, 0, 0));
        rows.push_back(mk_row(-7, 3, 0, 20, 30, 40, 0, 0, 0, 0, 2, 2, 0));
        rows.push_back(mk_row(-7, 3, 0, 20, 30, 40, 1, 0, 0, 0, 1, 3, 0));
        rows.push_back(mk_row(-7, 3, 0, 20, 31, 41, 0, 0, 0, 1, 7, 7, 0));
        rows.push_back(mk_row(32'h40000000, 32'hc0000000, 32'h40000000, 32'h40000000,
                              32'h40000000, 32'hc0000000, 0, 32'hc0000000, 32'h40000000,
                              0, 20'h80000, 20'h80000, 0));
        rows.push_back(mk_row(3, -3, 3, -3, 3, -3, 0, 0, -3, 0, 1, 1, 0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_HOME_LAT, 48'(32'h12345678));
        write_reg(REG_HOME_LON, 48'(32'hedcba987));
        for (int i = 0; i < rows.size(); i++)
        begin
            if (i == 5)
            begin
                drain();
                write_reg(REG_POS_GAINS, 48'h7fff_7fff_7fff);
                write_reg(REG_PITCH_GAINS, 48'h8000_8000_8000);
                write_reg(REG_ROLL_GAINS, 48'h7fff_8000_7fff);
                write_reg(REG_YAW_GAINS, 48'h0003_fffe_0001);
                write_reg(REG_ALT_GAINS, 48'h8000_7fff_8000);
                // home is latched once: these must change nothing
                write_reg(REG_HOME_LAT, 48'hffff_ffff_ffff);
                write_reg(REG_HOME_LON, 48'h0000_8000_0000);
                write_reg(REG_UNUSED, 48'hffff_ffff_ffff);
            end
            send_tick(rows[i].tick, rows[i].typed, rows[i].drv);
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            drain();
            quiet = (ph == 3);
            for (int r = REG_POS_GAINS; r <= REG_ALT_GAINS; r++)
            begin
                if (ph == 0) write_reg(CFG_IDX_W'(r), 48'h7fff_7fff_7fff);
                else if (ph == 1) write_reg(CFG_IDX_W'(r), 48'h8000_8000_8000);
                else if (ph == 2) write_reg(CFG_IDX_W'(r), '0);
                else write_reg(CFG_IDX_W'(r), rand_gains(ph % 2));
            end
            write_reg(REG_HOME_LAT, 48'($urandom()));
            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                // hold-off: let every outstanding result come back first
                if (n == PHASE_TICKS / 2)
                begin
                    in_ch.valid <= 1'b0;
                    while (pending_drives.size() != 0) @(posedge clk);
                end
                send_tick(rand_tick(), 1'b0, '0);
            end
        end
        quiet = 1'b0;

        drain();
        if (fail_count == 0)
            $display("cascaded_pid_attitude_controller_unit verification clean");
        else
            $display("cascaded_pid_attitude_controller_unit verification failed");
        $finish;
    end
endmodule
